// ===== rtl/tws_pkg.sv =====
package tws_pkg;

   // request command codes
   localparam logic [1:0] CMD_TICK       = 2'd0;
   localparam logic [1:0] CMD_LOAD_TOOTH = 2'd1;
   localparam logic [1:0] CMD_LOAD_GAP   = 2'd2;

   // field widths
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned INDEX_W  = 8;
   localparam int unsigned VALUE_W  = 16;
   localparam int unsigned LIMIT_W  = 8;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd58;

   // crank wheel marks
   localparam logic [7:0] SYNC_TOOTH   = 8'd30;
   localparam logic [7:0] SYNC_POS     = 8'd33;
   localparam logic [7:0] CAM_TOOTH_A  = 8'd10;
   localparam logic [7:0] CAM_TOOTH_B  = 8'd38;
   localparam logic [7:0] CAM_RISE_POS = 8'd22;
   localparam logic [7:0] CAM_FALL_POS = 8'd44;

   // table write port
   typedef struct packed {
      logic               tooth_en;
      logic               gap_en;
      logic [INDEX_W-1:0] addr;
      logic [VALUE_W-1:0] data;
   } wr_req_type;

   // table read port
   typedef struct packed {
      logic               en;
      logic               gap;
      logic [INDEX_W-1:0] addr;
   } rd_req_type;

   // per request status carried down the pipe
   typedef struct packed {
      logic sample_valid;
      logic sync_level;
      logic cam_level;
   } meta_type;

endpackage

// ===== rtl/tooth_waveform_sequencer.sv =====
// pipe: an accepted request goes to the table read stage, then to the output register
// throughput: one request per cycle, tick or load, unless a full read stage waits on a
// stalled response; the table memories read and write once per cycle, so a tick always
// sees a load accepted the cycle before; the output register offers the response
// reset: counters, sync and cam levels clear, tooth count limit returns to 58;
// waveform tables are not cleared and hold garbage until loaded
module tooth_waveform_sequencer
   import tws_pkg::*;
#(
   parameter int unsigned TOOTH_SAMPLES = 45,
   parameter int unsigned GAP_SAMPLES   = 135,
   parameter int unsigned SAMPLE_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [INDEX_W-1:0] req_index,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_sample_valid,
   output logic [VALUE_W-1:0] rsp_sample,
   output logic               rsp_sync_level,
   output logic               rsp_cam_level
);

   logic                   req_accept;
   logic                   tick;
   wr_req_type             wr;
   rd_req_type             rd;
   meta_type               meta;
   logic [SAMPLE_BITS-1:0] rd_data;

   logic                   s1_valid_ff, s1_valid_in;
   meta_type               s1_meta_ff;
   logic                   out_load;
   logic                   out_valid_ff, out_valid_in;
   meta_type               out_meta_ff;
   logic [VALUE_W-1:0]     out_sample_ff, out_sample_in;

   assign req_accept = req_valid && !req_stall;
   assign tick       = req_accept && (req_cmd == CMD_TICK);

   // table loads, out of range index dropped
   always_comb begin
      wr          = '0;
      wr.addr     = req_index;
      wr.data     = req_value;
      wr.tooth_en = req_accept && (req_cmd == CMD_LOAD_TOOTH)
                    && (32'(req_index) < TOOTH_SAMPLES);
      wr.gap_en   = req_accept && (req_cmd == CMD_LOAD_GAP)
                    && (32'(req_index) < GAP_SAMPLES);
   end

   tws_seq #(
      .TOOTH_SAMPLES(TOOTH_SAMPLES),
      .GAP_SAMPLES  (GAP_SAMPLES)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .tick     (tick),
      .rd       (rd),
      .meta     (meta)
   );

   tws_wave_mem #(
      .TOOTH_SAMPLES(TOOTH_SAMPLES),
      .GAP_SAMPLES  (GAP_SAMPLES),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_mem (
      .clock  (clock),
      .wr     (wr),
      .rd     (rd),
      .rd_data(rd_data)
   );

   // pipe control: read stage then output register
   assign out_load     = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !out_load;
   assign s1_valid_in  = req_accept || (s1_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && rsp_stall);
   assign out_sample_in = s1_meta_ff.sample_valid ? VALUE_W'(rd_data) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // read stage status
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_meta_ff <= meta;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_meta_ff   <= s1_meta_ff;
         out_sample_ff <= out_sample_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sample_valid = out_meta_ff.sample_valid;
   assign rsp_sample       = out_sample_ff;
   assign rsp_sync_level   = out_meta_ff.sync_level;
   assign rsp_cam_level    = out_meta_ff.cam_level;

   // a request can only be held off by a full read stage
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with empty read stage");

   // a response loaded from the read stage is offered next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("loaded response not offered");

   // a response with no sample carries zero
   a_no_sample_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_sample_valid) |-> (rsp_sample == '0))
      else $error("nonzero sample without sample valid");

endmodule

// ===== rtl/tws_wave_mem.sv =====
module tws_wave_mem
   import tws_pkg::*;
#(
   parameter int unsigned TOOTH_SAMPLES = 45,
   parameter int unsigned GAP_SAMPLES   = 135,
   parameter int unsigned SAMPLE_BITS   = 16
) (
   input  logic                   clock,
   input  wr_req_type             wr,
   input  rd_req_type             rd,
   output logic [SAMPLE_BITS-1:0] rd_data
);

   localparam int unsigned TA_W = (TOOTH_SAMPLES > 1) ? $clog2(TOOTH_SAMPLES) : 1;
   localparam int unsigned GA_W = (GAP_SAMPLES > 1) ? $clog2(GAP_SAMPLES) : 1;

   logic [SAMPLE_BITS-1:0] tooth_mem [TOOTH_SAMPLES];
   logic [SAMPLE_BITS-1:0] gap_mem [GAP_SAMPLES];
   logic [SAMPLE_BITS-1:0] tooth_q_ff;
   logic [SAMPLE_BITS-1:0] gap_q_ff;
   logic                   gap_sel_ff;

   // tooth table
   always_ff @(posedge clock) begin
      if (wr.tooth_en) begin
         tooth_mem[wr.addr[TA_W-1:0]] <= wr.data[SAMPLE_BITS-1:0];
      end
      if (rd.en && !rd.gap) begin
         tooth_q_ff <= tooth_mem[rd.addr[TA_W-1:0]];
      end
   end

   // gap table
   always_ff @(posedge clock) begin
      if (wr.gap_en) begin
         gap_mem[wr.addr[GA_W-1:0]] <= wr.data[SAMPLE_BITS-1:0];
      end
      if (rd.en && rd.gap) begin
         gap_q_ff <= gap_mem[rd.addr[GA_W-1:0]];
      end
   end

   // remember which table the last read hit
   always_ff @(posedge clock) begin
      if (rd.en) begin
         gap_sel_ff <= rd.gap;
      end
   end

   assign rd_data = gap_sel_ff ? gap_q_ff : tooth_q_ff;

endmodule

// ===== rtl/tws_seq.sv =====
module tws_seq
   import tws_pkg::*;
#(
   parameter int unsigned TOOTH_SAMPLES = 45,
   parameter int unsigned GAP_SAMPLES   = 135
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata,
   input  logic               tick,
   output rd_req_type         rd,
   output meta_type           meta
);

   localparam int unsigned TP_W = $clog2(TOOTH_SAMPLES + 1);
   localparam int unsigned GP_W = $clog2(GAP_SAMPLES + 1);
   localparam logic [TP_W-1:0] TOOTH_LAST = TP_W'(TOOTH_SAMPLES);
   localparam logic [GP_W-1:0] GAP_LAST   = GP_W'(GAP_SAMPLES);

   logic [LIMIT_W-1:0] limit_ff;
   logic [TP_W-1:0]    tpos_ff, tpos_in;
   logic [7:0]         tnum_ff, tnum_in;
   logic [GP_W-1:0]    gpos_ff, gpos_in;
   logic               sync_ff, sync_in;
   logic               cam_ff, cam_in;
   logic [7:0]         tpos_ext;
   logic               cam_tooth;

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // counter update and table read on tick
   always_comb begin
      tpos_in   = tpos_ff;
      tnum_in   = tnum_ff;
      gpos_in   = gpos_ff;
      sync_in   = sync_ff;
      cam_in    = cam_ff;
      tpos_ext  = '0;
      cam_tooth = 1'b0;
      rd        = '0;
      meta      = '0;
      if (tick) begin
         if (tnum_ff < limit_ff) begin
            if (tpos_ff < TOOTH_LAST) begin
               rd.en             = 1'b1;
               rd.addr           = INDEX_W'(tpos_ff);
               meta.sample_valid = 1'b1;
               tpos_in           = tpos_ff + 1'b1;
            end else begin
               tpos_in = '0;
               tnum_in = tnum_ff + 8'd1;
            end
            // marks checked on updated counters
            tpos_ext  = 8'(tpos_in);
            cam_tooth = (tnum_in == CAM_TOOTH_A) || (tnum_in == CAM_TOOTH_B);
            if (tnum_in == SYNC_TOOTH && tpos_ext == SYNC_POS) begin
               sync_in = ~sync_ff;
            end else if (cam_tooth && tpos_ext == CAM_RISE_POS) begin
               cam_in = 1'b1;
            end else if (cam_tooth && tpos_ext == CAM_FALL_POS) begin
               cam_in = 1'b0;
            end
         end else begin
            if (gpos_ff < GAP_LAST) begin
               rd.en             = 1'b1;
               rd.gap            = 1'b1;
               rd.addr           = INDEX_W'(gpos_ff);
               meta.sample_valid = 1'b1;
               gpos_in           = gpos_ff + 1'b1;
            end else begin
               gpos_in = '0;
               tnum_in = '0;
            end
         end
      end
      meta.sync_level = sync_in;
      meta.cam_level  = cam_in;
   end

   // counter state
   always_ff @(posedge clock) begin
      if (reset) begin
         tpos_ff <= '0;
         tnum_ff <= '0;
         gpos_ff <= '0;
         sync_ff <= 1'b0;
         cam_ff  <= 1'b0;
      end else begin
         tpos_ff <= tpos_in;
         tnum_ff <= tnum_in;
         gpos_ff <= gpos_in;
         sync_ff <= sync_in;
         cam_ff  <= cam_in;
      end
   end

endmodule

// ===== tb/sv/tb_tooth_waveform_sequencer.sv =====
`timescale 1ns / 100ps

module tb_tooth_waveform_sequencer;
   import tws_pkg::*;

   localparam int unsigned TOOTH_SAMPLES = 45;
   localparam int unsigned GAP_SAMPLES   = 135;
   localparam int unsigned SAMPLE_BITS   = 16;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned HOLD_CYCLES   = 80;

   // unused command code, the block ignores it
   localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
   } wheel_req_type;

   typedef struct packed {
      logic               sample_valid;
      logic [VALUE_W-1:0] sample;
      logic               sync_level;
      logic               cam_level;
   } wheel_out_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               csr_we    = 1'b0;
   logic [LIMIT_W-1:0] csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [CMD_W-1:0]   req_cmd   = CMD_TICK;
   logic [INDEX_W-1:0] req_index = '0;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_sample_valid;
   logic [VALUE_W-1:0] rsp_sample;
   logic               rsp_sync_level;
   logic               rsp_cam_level;

   // stimulus and checking state
   wheel_req_type  wheel_pending[$];
   wheel_out_type  wheel_expected[$];
   wheel_req_type  drive_item;
   wheel_out_type  want;
   int unsigned wheel_pushed   = 0;
   int unsigned wheel_accepted = 0;
   int unsigned err_count      = 0;
   int unsigned cycle_count    = 0;
   int unsigned tx_idle_pct    = 0;
   int unsigned rx_idle_pct    = 0;
   int unsigned hold_left      = 0;
   logic        hold_request   = 1'b0;
   logic        hold_taken     = 1'b0;
   logic        req_fire       = 1'b0;

   // predicted crank wheel state
   logic [VALUE_W-1:0] tooth_wave [TOOTH_SAMPLES];
   logic [VALUE_W-1:0] gap_wave [GAP_SAMPLES];
   int unsigned        pos_in_tooth;
   int unsigned        pos_in_gap;
   logic [7:0]         tooth_idx;
   logic               sync_lvl;
   logic               cam_lvl;
   logic [LIMIT_W-1:0] tooth_limit;

   // run statistics
   int unsigned tick_count   = 0;
   int unsigned sample_count = 0;
   int unsigned sync_toggles = 0;
   int unsigned cam_rises    = 0;
   int unsigned gap_laps     = 0;

   tooth_waveform_sequencer #(
      .TOOTH_SAMPLES(TOOTH_SAMPLES),
      .GAP_SAMPLES  (GAP_SAMPLES),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_index       (req_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_valid(rsp_sample_valid),
      .rsp_sample      (rsp_sample),
      .rsp_sync_level  (rsp_sync_level),
      .rsp_cam_level   (rsp_cam_level)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // advance the predicted wheel by one request and return its response
   function automatic wheel_out_type spin_wheel(input wheel_req_type r);
      wheel_out_type o;
      logic          cam_tooth;
      o = '0;
      case (r.cmd)
         CMD_LOAD_TOOTH: begin
            if (r.index < TOOTH_SAMPLES) tooth_wave[r.index] = r.value;
         end
         CMD_LOAD_GAP: begin
            if (r.index < GAP_SAMPLES) gap_wave[r.index] = r.value;
         end
         CMD_TICK: begin
            tick_count++;
            if (tooth_idx < tooth_limit) begin
               if (pos_in_tooth < TOOTH_SAMPLES) begin
                  o.sample_valid = 1'b1;
                  o.sample       = tooth_wave[pos_in_tooth];
                  pos_in_tooth++;
               end else begin
                  pos_in_tooth = 0;
                  tooth_idx    = tooth_idx + 8'd1;
               end
               // sync and cam marks, checked on the updated counters
               cam_tooth = (tooth_idx == CAM_TOOTH_A) || (tooth_idx == CAM_TOOTH_B);
               if (tooth_idx == SYNC_TOOTH && pos_in_tooth == SYNC_POS) begin
                  sync_lvl = ~sync_lvl;
                  sync_toggles++;
               end else if (cam_tooth && pos_in_tooth == CAM_RISE_POS) begin
                  cam_lvl = 1'b1;
                  cam_rises++;
               end else if (cam_tooth && pos_in_tooth == CAM_FALL_POS) begin
                  cam_lvl = 1'b0;
               end
            end else begin
               if (pos_in_gap < GAP_SAMPLES) begin
                  o.sample_valid = 1'b1;
                  o.sample       = gap_wave[pos_in_gap];
                  pos_in_gap++;
               end else begin
                  pos_in_gap = 0;
                  tooth_idx  = '0;
                  gap_laps++;
               end
            end
         end
         default: ;
      endcase
      o.sync_level = sync_lvl;
      o.cam_level  = cam_lvl;
      return o;
   endfunction

   // monitor: check responses, track register writes, predict accepted requests
   always @(posedge clock) begin
      if (reset) begin
         pos_in_tooth = 0;
         pos_in_gap   = 0;
         tooth_idx    = '0;
         sync_lvl     = 1'b0;
         cam_lvl      = 1'b0;
         tooth_limit  = LIMIT_RESET;
         req_fire     = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (wheel_expected.size() == 0) begin
               $error("response with no request outstanding");
               err_count++;
            end else begin
               want = wheel_expected.pop_front();
               if (want.sample_valid) sample_count++;
               if (rsp_sample_valid !== want.sample_valid) begin
                  $error("sample_valid: expected %0d, got %0d",
                         want.sample_valid, rsp_sample_valid);
                  err_count++;
               end
               if (rsp_sample !== want.sample) begin
                  $error("sample: expected %h, got %h", want.sample, rsp_sample);
                  err_count++;
               end
               if (rsp_sync_level !== want.sync_level) begin
                  $error("sync_level: expected %0d, got %0d",
                         want.sync_level, rsp_sync_level);
                  err_count++;
               end
               if (rsp_cam_level !== want.cam_level) begin
                  $error("cam_level: expected %0d, got %0d",
                         want.cam_level, rsp_cam_level);
                  err_count++;
               end
            end
         end
         if (csr_we) tooth_limit = csr_wdata;
         req_fire = req_valid && !req_stall;
         if (req_fire) begin
            wheel_expected.push_back(spin_wheel('{req_cmd, req_index, req_value}));
            wheel_accepted++;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (wheel_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            drive_item = wheel_pending.pop_front();
            req_valid <= 1'b1;
            req_cmd   <= drive_item.cmd;
            req_index <= drive_item.index;
            req_value <= drive_item.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall, with one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] index,
                            input logic [VALUE_W-1:0] value);
      wheel_pending.push_back('{cmd, index, value});
      wheel_pushed++;
   endtask

   // mostly ticks, the rest loads (some out of range) and ignored codes
   task automatic queue_random(input int unsigned count, input int unsigned tick_pct);
      logic [INDEX_W-1:0] idx;
      logic [VALUE_W-1:0] val;
      for (int unsigned n = 0; n < count; n++) begin
         val = VALUE_W'($urandom());
         idx = INDEX_W'($urandom());
         if ($urandom_range(99) < tick_pct) begin
            push_item(CMD_TICK, idx, val);
         end else begin
            case ($urandom_range(2))
               0: begin
                  if ($urandom_range(3) != 0) idx = INDEX_W'($urandom_range(TOOTH_SAMPLES - 1));
                  push_item(CMD_LOAD_TOOTH, idx, val);
               end
               1: begin
                  if ($urandom_range(3) != 0) idx = INDEX_W'($urandom_range(GAP_SAMPLES - 1));
                  push_item(CMD_LOAD_GAP, idx, val);
               end
               default: push_item(CMD_NOP, idx, val);
            endcase
         end
      end
   endtask

   // sender holds until every response is back and the pipe is empty
   task automatic wait_drained();
      while (wheel_pending.size() != 0 || wheel_accepted != wheel_pushed ||
             wheel_expected.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] lim);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= lim;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // stimulus sequence
   initial begin
      tx_idle_pct = 27;
      rx_idle_pct = 57;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // fill both tables before any tick can read them
      for (int unsigned i = 0; i < TOOTH_SAMPLES; i++)
         push_item(CMD_LOAD_TOOTH, INDEX_W'(i), VALUE_W'($urandom()));
      for (int unsigned i = 0; i < GAP_SAMPLES; i++)
         push_item(CMD_LOAD_GAP, INDEX_W'(i), VALUE_W'($urandom()));

      // field extremes, out of range loads, ignored code
      push_item(CMD_LOAD_TOOTH, 8'd0, 16'hFFFF);
      push_item(CMD_LOAD_TOOTH, 8'd44, 16'h0000);
      push_item(CMD_LOAD_TOOTH, 8'd45, 16'h5A5A);
      push_item(CMD_LOAD_TOOTH, 8'hFF, 16'hFFFF);
      push_item(CMD_LOAD_GAP, 8'd0, 16'h0000);
      push_item(CMD_LOAD_GAP, 8'd134, 16'hFFFF);
      push_item(CMD_LOAD_GAP, 8'd135, 16'hA5A5);
      push_item(CMD_LOAD_GAP, 8'hFF, 16'h0000);
      push_item(CMD_NOP, 8'hFF, 16'hFFFF);
      push_item(CMD_NOP, 8'h00, 16'h0000);
      push_item(CMD_TICK, 8'hFF, 16'hFFFF);
      push_item(CMD_TICK, 8'h00, 16'h0000);
      push_item(CMD_TICK, 8'hAA, 16'h5555);
      for (int unsigned i = 0; i < 4; i++) push_item(CMD_TICK, 8'h55, 16'hAAAA);

      // long run at the reset limit, walking past the first cam tooth
      queue_random(270, 97);
      wait_drained();
      queue_random(270, 97);
      wait_drained();
      tx_idle_pct = 57;
      rx_idle_pct = 27;
      queue_random(280, 97);
      wait_drained();

      // largest limit, no idling, long receiver hold-off so the input backs up
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_limit(8'd255);
      hold_request = 1'b1;
      queue_random(100, 90);
      wait_drained();

      // zero limit: the gap plays back to back
      write_limit(8'd0);
      queue_random(100, 90);
      wait_drained();

      // a single tooth between gaps
      write_limit(8'd1);
      queue_random(150, 90);
      wait_drained();

      $display("requests %0d, ticks %0d, samples %0d, gap laps %0d",
               wheel_accepted, tick_count, sample_count, gap_laps);
      $display("sync toggles %0d, cam pulses %0d, mismatches %0d",
               sync_toggles, cam_rises, err_count);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== tooth_waveform_sequencer.f =====
rtl/tws_pkg.sv
rtl/tws_wave_mem.sv
rtl/tws_seq.sv
rtl/tooth_waveform_sequencer.sv
tb/sv/tb_tooth_waveform_sequencer.sv
